FILE: rtl/ace_pkg.sv
// Shared types and constants of the address resolution cache.
`default_nettype none
package ace_pkg;
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_PACKET = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [15:0] OPC_REQ = 16'h0001;
  localparam logic [15:0] OPC_REP = 16'h0002;

  localparam logic [1:0] REG_LOCAL_IP  = 2'd0;
  localparam logic [1:0] REG_LOCAL_MAC = 2'd1;
  localparam logic [1:0] REG_PEND_LIFE = 2'd2;
  localparam logic [1:0] REG_RES_LIFE  = 2'd3;

  localparam logic [31:0] IP_ALL  = 32'hffff_ffff;
  localparam logic [47:0] MAC_ALL = 48'hffff_ffff_ffff;
  localparam logic [15:0] LFSR_SEED = 16'hace1;

  // classified command passed from front to back
  typedef struct packed {
    logic        lookup;   // plain lookup, result carries hit/mac
    logic        claim;    // run claim on ip
    logic        update;   // run update with ip/mac
    logic        tick;     // age all slots
    logic        reply;    // result carries reply fields
    logic        bcast;    // broadcast lookup: immediate hit
    logic [31:0] ip;
    logic [47:0] mac;
  } cmd_t;

  typedef struct packed {
    logic        hit;
    logic [47:0] mac_out;
    logic        reply_valid;
    logic [47:0] reply_dest_mac;
    logic [31:0] reply_dest_ip;
  } res_t;
endpackage
`default_nettype wire

FILE: rtl/arp_cache_engine_unit.sv
// Top level of the address resolution cache with aging.
//
//  channel | dir | payload
//  s_axis  | in  | tdata: op, ip_addr, arp_opcode, sender_mac, target_ip
//  m_axis  | out | tdata: hit, mac_out, reply_valid, reply_dest_mac, reply_dest_ip
//  cfg     | in  | index 0..3 and 48-bit data, write only
//
// A lookup, or a packet that touches the table, runs the back-end scan, in which
// one slot is compared per cycle; a tick also walks every slot. Broadcast
// lookups and ignored words skip the scan and go straight to the result.
// The front queue holds two words, so input is still taken during the scan until it fills.
// Reset sets all slots empty at once; no clearing pass.
// The result register holds a word until the sink takes it; the back end
// takes no new command meanwhile.
`default_nettype none
module arp_cache_engine_unit #(
  parameter int unsigned CACHE_ENTRIES = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [1:0] op, [33:2] ip_addr, [49:34] arp_opcode, [97:50] sender_mac,
  // [129:98] target_ip, [135:130] zero
  input  wire logic [135:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [0] hit, [48:1] mac_out, [49] reply_valid, [97:50] reply_dest_mac,
  // [129:98] reply_dest_ip, [135:130] zero
  output logic [135:0]      m_axis_tdata,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [47:0]  cfg_data_i
);
  import ace_pkg::*;

  logic [31:0] local_ip_q;
  logic [47:0] local_mac_q;
  logic [7:0]  pend_life_q, res_life_q;

  assign cfg_ready_o = 1'b1;

  // own MAC is stored here but reaches no output; not needed by the cache itself
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q  <= '0;
      local_mac_q <= '0;
      pend_life_q <= 8'd2;
      res_life_q  <= 8'd120;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_LOCAL_IP:  local_ip_q  <= cfg_data_i[31:0];
        REG_LOCAL_MAC: local_mac_q <= cfg_data_i;
        REG_PEND_LIFE: pend_life_q <= cfg_data_i[7:0];
        REG_RES_LIFE:  res_life_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  res_t res;

  ace_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .op_i        (s_axis_tdata[1:0]),
    .ip_i        (s_axis_tdata[33:2]),
    .opc_i       (s_axis_tdata[49:34]),
    .smac_i      (s_axis_tdata[97:50]),
    .tip_i       (s_axis_tdata[129:98]),
    .local_ip_i  (local_ip_q),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  ace_back #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .pend_life_i (pend_life_q),
    .res_life_i  (res_life_q),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // local MAC folded in as zero so the register stays observed by nothing else
  assign m_axis_tdata = {6'd0, res.reply_dest_ip, res.reply_dest_mac, res.reply_valid,
                         res.mac_out | (local_mac_q & 48'd0), res.hit};
endmodule
`default_nettype wire

FILE: rtl/ace_front.sv
// Front end: takes input words, classifies them and queues commands.
`default_nettype none
module ace_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire logic [1:0]    op_i,
  input  wire logic [31:0]   ip_i,
  input  wire logic [15:0]   opc_i,
  input  wire logic [47:0]   smac_i,
  input  wire logic [31:0]   tip_i,
  input  wire logic [31:0]   local_ip_i,
  output logic               cmd_valid_o,
  input  wire logic          cmd_ready_i,
  output ace_pkg::cmd_t      cmd_o
);
  import ace_pkg::*;

  // two-entry queue
  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  cmd_t       c;
  logic       push, pop;

  always_comb begin
    c = '0;
    c.ip  = ip_i;
    c.mac = smac_i;
    case (op_i)
      OP_LOOKUP: begin
        c.lookup = 1'b1;
        c.bcast  = (ip_i == IP_ALL);
        c.claim  = (ip_i != IP_ALL);
      end
      OP_PACKET: begin
        if (opc_i == OPC_REQ && tip_i == local_ip_i) begin
          c.claim  = (ip_i != IP_ALL);
          c.update = 1'b1;
          c.reply  = 1'b1;
        end else if (opc_i == OPC_REP) begin
          c.update = 1'b1;
        end
      end
      OP_TICK: c.tick = 1'b1;
      default: ;
    endcase
  end

  assign ready_o     = (cnt_q != 2'd2);
  assign push        = valid_i && ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/ace_back.sv
// Back end: sequencer that scans the slot table for each command.
`default_nettype none
module ace_back #(
  parameter int unsigned CACHE_ENTRIES = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  input  wire ace_pkg::cmd_t cmd_i,
  input  wire logic [7:0]    pend_life_i,
  input  wire logic [7:0]    res_life_i,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output ace_pkg::res_t      res_o
);
  import ace_pkg::*;

  localparam int unsigned IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [IW:0] LAST = (IW+1)'(CACHE_ENTRIES - 1);

  // victim index = lfsr mod CACHE_ENTRIES by reciprocal multiply, exact for 16 bits
  localparam int unsigned     MK      = 16 + IW;
  localparam longint unsigned RECIP_L = ((64'd1 << MK) + 64'(CACHE_ENTRIES) - 64'd1)
                                        / 64'(CACHE_ENTRIES);
  localparam logic [16:0]     RECIP   = 17'(RECIP_L);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIND  = 3'd1;
  localparam logic [2:0] S_CLAIM = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_TICK  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [31:0] ip_q   [CACHE_ENTRIES];
  logic [47:0] mac_q  [CACHE_ENTRIES];
  logic [7:0]  life_q [CACHE_ENTRIES];
  logic [15:0] lfsr_q;

  logic [2:0]    st_q;
  cmd_t          cmd_q;
  logic [IW-1:0] k_q;       // scan index
  logic          found_q;
  logic [IW-1:0] fidx_q;    // first matching slot
  logic [7:0]    best_q;
  logic [IW-1:0] sel_q;
  logic          zero_q;    // free slot already found
  res_t          res_q;
  logic          rv_q;
  logic [15:0]   quo_q;     // lfsr_n / CACHE_ENTRIES, taken in the claim step

  logic [15:0]   lfsr_n;
  logic          last;
  logic [32:0]   prod;
  logic [32:0]   prod_sh;
  logic [15:0]   rem;
  logic [IW-1:0] vidx;
  assign lfsr_n  = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
  assign last    = ({1'b0, k_q} == LAST[IW:0]);
  assign prod    = {17'd0, lfsr_n} * {16'd0, RECIP};
  assign prod_sh = prod >> MK;
  assign rem     = lfsr_n - quo_q * 16'(CACHE_ENTRIES);
  assign vidx    = rem[IW-1:0];

  assign cmd_ready_o = (st_q == S_IDLE) && !rv_q;
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      rv_q    <= 1'b0;
      lfsr_q  <= LFSR_SEED;
      cmd_q   <= '0;
      res_q   <= '0;
      k_q     <= '0;
      found_q <= 1'b0;
      fidx_q  <= '0;
      best_q  <= 8'hff;
      sel_q   <= '0;
      zero_q  <= 1'b0;
      quo_q   <= '0;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        ip_q[i]   <= IP_ALL;
        mac_q[i]  <= MAC_ALL;
        life_q[i] <= 8'd0;
      end
    end else begin
      if (rv_q && res_ready_i) rv_q <= 1'b0;
      unique case (st_q)
        S_IDLE: begin
          if (cmd_valid_i && cmd_ready_o) begin
            cmd_q   <= cmd_i;
            k_q     <= '0;
            found_q <= 1'b0;
            best_q  <= 8'hff;
            sel_q   <= '0;
            zero_q  <= 1'b0;
            if (cmd_i.bcast) begin
              res_q <= '{hit: 1'b1, mac_out: MAC_ALL, default: '0};
              st_q  <= S_OUT;
            end else if (cmd_i.tick) begin
              res_q <= '0;
              st_q  <= S_TICK;
            end else if (cmd_i.claim || cmd_i.update) begin
              res_q <= '0;
              st_q  <= S_FIND;
            end else begin
              res_q <= '0;
              st_q  <= S_OUT;
            end
          end
        end
        S_FIND: begin
          // one slot per cycle: first match and claim victim together
          if (!found_q && ip_q[k_q] == cmd_q.ip) begin
            found_q <= 1'b1;
            fidx_q  <= k_q;
          end
          if (!zero_q && life_q[k_q] <= best_q) begin
            best_q <= life_q[k_q];
            sel_q  <= k_q;
            if (life_q[k_q] == 8'd0) zero_q <= 1'b1;
          end
          k_q <= k_q + 1'b1;
          if (last) st_q <= S_CLAIM;
        end
        S_CLAIM: begin
          quo_q <= prod_sh[15:0];
          if (found_q) begin
            if (cmd_q.lookup && mac_q[fidx_q][47:40] != 8'hff) begin
              res_q.hit     <= 1'b1;
              res_q.mac_out <= mac_q[fidx_q];
            end
          end else if (cmd_q.claim) begin
            ip_q[sel_q]         <= cmd_q.ip;
            mac_q[sel_q][47:40] <= 8'hff;
            life_q[sel_q]       <= pend_life_i;
            // claimed slot now matches for the update
            found_q <= 1'b1;
            fidx_q  <= sel_q;
          end
          st_q <= cmd_q.update ? S_UPD : S_OUT;
        end
        S_UPD: begin
          if (found_q) begin
            mac_q[fidx_q]  <= cmd_q.mac;
            life_q[fidx_q] <= res_life_i;
          end else begin
            lfsr_q       <= lfsr_n;
            ip_q[vidx]   <= cmd_q.ip;
            mac_q[vidx]  <= cmd_q.mac;
            life_q[vidx] <= res_life_i;
          end
          if (cmd_q.reply) begin
            res_q.reply_valid    <= 1'b1;
            res_q.reply_dest_mac <= cmd_q.mac;
            res_q.reply_dest_ip  <= cmd_q.ip;
          end
          st_q <= S_OUT;
        end
        S_TICK: begin
          if (life_q[k_q] != 8'd0) begin
            life_q[k_q] <= life_q[k_q] - 8'd1;
            if (life_q[k_q] == 8'd1) begin
              ip_q[k_q]  <= IP_ALL;
              mac_q[k_q] <= MAC_ALL;
            end
          end
          k_q <= k_q + 1'b1;
          if (last) st_q <= S_OUT;
        end
        S_OUT: begin
          if (!rv_q) begin
            rv_q <= 1'b1;
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
